FILE: rtl/dvad_pkg.sv
// dvad_pkg: types, constants and helper functions for the dv audio deshuffle block
// depends on nothing; imported by every rtl file of the block except dvad_ram
package dvad_pkg;

    // frame and map sizes
    localparam int FRAME_BYTES  = 144000;
    localparam int PAL_PAIRS    = 1944;
    localparam int NTSC_PAIRS   = 1620;
    localparam int ADDR_W       = 18;
    localparam int INDEX_W      = 11;
    localparam int COUNT_W      = 11;
    localparam int SAMPLE_W     = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;

    // frame layout
    localparam logic [ADDR_W-1:0] HDR_ADDR     = 18'd3;
    localparam logic [ADDR_W-1:0] PROBE_FIRST  = 18'd483;
    localparam logic [ADDR_W-1:0] BLOCK_STEP   = 18'd1280;
    localparam logic [ADDR_W-1:0] SEQ_WRAP     = 18'd1760;
    localparam logic [ADDR_W-1:0] SEQ_BYTES    = 18'd12000;
    localparam logic [ADDR_W-1:0] PAL_HALF     = 18'd72000;
    localparam logic [ADDR_W-1:0] NTSC_HALF    = 18'd60000;
    localparam logic [7:0]        PACK_ID      = 8'h50;

    // base pair counts per rate and frame rate
    localparam logic [COUNT_W-1:0] BASE_48K_60 = 11'd1580;
    localparam logic [COUNT_W-1:0] BASE_44K_60 = 11'd1452;
    localparam logic [COUNT_W-1:0] BASE_32K_60 = 11'd1053;
    localparam logic [COUNT_W-1:0] BASE_48K_50 = 11'd1896;
    localparam logic [COUNT_W-1:0] BASE_32K_50 = 11'd1264;

    // reciprocals for constant division (scaled by 2^13 or 2^16)
    localparam logic [11:0] RECIP_3    = 12'd2731;
    localparam logic [10:0] RECIP_54   = 11'd1214;
    localparam logic [10:0] RECIP_45   = 11'd1457;
    localparam logic [13:0] RECIP_6    = 14'd10923;
    localparam logic [13:0] RECIP_5    = 14'd13108;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ANALYZE = 2'd1,
        OP_READ    = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_INFO  = 2'd1,
        ST_BAD_RATE = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RATE_48K     = 2'd0,
        RATE_44K1    = 2'd1,
        RATE_32K     = 2'd2,
        RATE_UNKNOWN = 2'd3
    } rate_t;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_ANALYZE = 2'd1,
        CMD_READ    = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FM_PCM16 = 2'd0,
        FM_PCM12 = 2'd1,
        FM_PACK  = 2'd2
    } fetch_mode_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CALC1,
        BK_CALC2,
        BK_CALC3,
        BK_CALC4,
        BK_FETCH,
        BK_HDR_RD,
        BK_HDR_WAIT,
        BK_PROBE_RD,
        BK_PROBE_CHK,
        BK_LATCH,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ADDR_W-1:0]  byte_addr;
        logic [7:0]         byte_value;
        logic [INDEX_W-1:0] sample_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [COUNT_W-1:0]         sample_count;
        logic [1:0]                 rate_code;
        logic                       is_pal;
        logic                       fifty_field;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         value;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // 12-bit nonlinear code to 16-bit linear sample
    function automatic logic signed [SAMPLE_W-1:0] expand12(input logic [11:0] y);
        logic              neg;
        logic [10:0]       p;
        logic [2:0]        sh;
        logic [SAMPLE_W-1:0] v;
        neg = y[11];
        p   = neg ? ~y[10:0] : y[10:0];
        sh  = 3'(p[10:8] - 3'd1);
        if (p < 11'h200)
            v = {5'b0, p};
        else
            v = SAMPLE_W'(11'(p - {sh, 8'h00})) << sh;
        return neg ? ~v : v;
    endfunction

endpackage

FILE: rtl/dvad_ram.sv
// dvad_ram: generic single-port ram with registered read
// depends on nothing
module dvad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else
            rdata <= mem[addr];
    end

endmodule

FILE: rtl/dvad_front.sv
// dvad_front: accepts input transactions and turns them into back-end commands
// depends on dvad_pkg
module dvad_front
    import dvad_pkg::*;
(
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     queue_full,
    output push_t    push
);

    logic keep;

    // stall only while the queue has no room
    assign item_stall = queue_full;

    // drop unused opcodes and writes outside the frame
    always_comb
    begin
        keep = 1'b1;
        push.cmd.kind = CMD_READ;
        case (item.opcode)
            OP_WRITE:
            begin
                push.cmd.kind = CMD_WRITE;
                keep = (item.byte_addr < ADDR_W'(FRAME_BYTES));
            end
            OP_ANALYZE: push.cmd.kind = CMD_ANALYZE;
            OP_READ:    push.cmd.kind = CMD_READ;
            default:    keep = 1'b0;
        endcase
        push.cmd.addr  = item.byte_addr;
        push.cmd.value = item.byte_value;
        push.cmd.index = item.sample_index;
        push.valid     = item_valid && !queue_full && keep;
    end

endmodule

FILE: rtl/dvad_queue.sv
// dvad_queue: short command queue between front and back
// depends on dvad_pkg
module dvad_queue
    import dvad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output cmd_t  q_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && q_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push.valid && !(pop && q_valid))
                count_reg <= count_reg + 1'b1;
            else if (!push.valid && pop && q_valid)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/dvad_back.sv
// dvad_back: command sequencer over the frame memory (writes, pack scan, sample fetch)
// depends on dvad_pkg
module dvad_back
    import dvad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output mem_req_t  mem_req,
    input  logic [7:0] mem_rdata,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    back_state_t state_reg, state_next;

    // latched frame info
    logic               info_valid_reg;
    logic [1:0]         rate_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               fifty_reg;
    logic               pal_reg;

    // per-command working registers
    logic [1:0]         status_reg;
    logic               is_read_reg;
    fetch_mode_t        mode_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [9:0]         q3_reg;
    logic [5:0]         qg_reg;
    logic [3:0]         blk_reg;
    logic [6:0]         byt_reg;
    logic [9:0]         seqsum_reg;
    logic [6:0]         seqq_reg;
    logic [ADDR_W-1:0]  a_reg;
    logic [ADDR_W-1:0]  b_reg;
    logic [2:0]         fcnt_reg;
    logic [7:0]         byte_reg [4];
    logic [ADDR_W-1:0]  probe_reg;
    logic [3:0]         seq_cnt_reg;
    logic [3:0]         blk_cnt_reg;
    logic               result_valid_reg;
    out_item_t          result_reg;

    // datapath terms
    logic [22:0]        prod3;
    logic [21:0]        prodg;
    logic [10:0]        grp;
    logic [5:0]         sub;
    logic [1:0]         r3;
    logic [5:0]         remg;
    logic [1:0]         subsel;
    logic [23:0]        prods;
    logic [2:0]         seq;
    logic [3:0]         nseq;
    logic [ADDR_W-1:0]  addr_a;
    logic [2:0]         fetch_len;
    logic [ADDR_W-1:0]  fetch_addr;
    logic               fetch_done;
    logic               probe_hit;
    logic               probe_last;
    logic               out_free;
    logic [1:0]         read_status;
    logic [COUNT_W-1:0] base_cnt;
    logic [COUNT_W-1:0] new_cnt;
    logic [COUNT_W-1:0] lim_cnt;
    logic [2:0]         smp;
    logic [1:0]         new_rate;
    logic               new_fifty;
    logic signed [SAMPLE_W-1:0] left_w;
    logic signed [SAMPLE_W-1:0] right_w;

    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // status of a read decided at dispatch
    always_comb
    begin
        if (!info_valid_reg)
            read_status = ST_NO_INFO;
        else if (rate_reg == RATE_UNKNOWN)
            read_status = ST_BAD_RATE;
        else if (q_cmd.index >= count_reg)
            read_status = ST_RANGE;
        else
            read_status = ST_OK;
    end

    // shuffle address arithmetic, spread over the calc stages
    always_comb
    begin
        grp    = pal_reg ? 11'd54 : 11'd45;
        sub    = pal_reg ? 6'd18 : 6'd15;
        nseq   = pal_reg ? 4'd6 : 4'd5;
        prod3  = 23'(idx_reg) * 23'(RECIP_3);
        prodg  = 22'(idx_reg) * 22'(pal_reg ? RECIP_54 : RECIP_45);
        r3     = 2'(idx_reg - 11'(q3_reg) * 11'd3);
        remg   = 6'(idx_reg - 11'(qg_reg) * grp);
        if (remg >= 6'(2 * sub))
            subsel = 2'd2;
        else if (remg >= sub)
            subsel = 2'd1;
        else
            subsel = 2'd0;
        prods  = 24'(seqsum_reg) * 24'(pal_reg ? RECIP_6 : RECIP_5);
        seq    = 3'(seqsum_reg - 10'(seqq_reg) * 10'(nseq));
        addr_a = 18'(seq) * SEQ_BYTES + 18'((18'd6 + 18'(blk_reg) * 18'd16) * 18'd80)
                 + 18'(byt_reg);
    end

    // fetch addresses for the byte burst
    always_comb
    begin
        fetch_len  = (mode_reg == FM_PCM16) ? 3'd4 : 3'd3;
        fetch_done = (fcnt_reg == fetch_len);
        case (mode_reg)
            FM_PCM16:
                fetch_addr = (fcnt_reg[1] ? b_reg : a_reg) + 18'(fcnt_reg[0]);
            FM_PCM12:
                fetch_addr = a_reg + 18'(fcnt_reg[1:0]);
            FM_PACK:
            begin
                if (fcnt_reg == 3'd0)
                    fetch_addr = a_reg + 18'd1;
                else if (fcnt_reg == 3'd1)
                    fetch_addr = a_reg + 18'd3;
                else
                    fetch_addr = a_reg + 18'd4;
            end
            default: fetch_addr = a_reg;
        endcase
    end

    // pack scan end conditions
    assign probe_hit  = (mem_rdata == PACK_ID);
    assign probe_last = (blk_cnt_reg == 4'd8) && (seq_cnt_reg == (pal_reg ? 4'd11 : 4'd9));

    // source pack decode
    always_comb
    begin
        smp       = byte_reg[2][5:3];
        new_fifty = byte_reg[1][5];
        new_rate  = (smp <= 3'd2) ? smp[1:0] : RATE_UNKNOWN;
        case (new_rate)
            RATE_48K:  base_cnt = new_fifty ? BASE_48K_50 : BASE_48K_60;
            RATE_44K1: base_cnt = BASE_44K_60;
            RATE_32K:  base_cnt = new_fifty ? BASE_32K_50 : BASE_32K_60;
            default:   base_cnt = '0;
        endcase
        if (new_rate == RATE_UNKNOWN || (new_rate == RATE_44K1 && new_fifty))
            new_cnt = '0;
        else
            new_cnt = base_cnt + 11'(byte_reg[0][5:0]);
        lim_cnt = pal_reg ? COUNT_W'(PAL_PAIRS) : COUNT_W'(NTSC_PAIRS);
    end

    // sample assembly
    always_comb
    begin
        if (!is_read_reg || status_reg != ST_OK)
        begin
            left_w  = '0;
            right_w = '0;
        end
        else if (mode_reg == FM_PCM12)
        begin
            left_w  = expand12({byte_reg[0], byte_reg[2][7:4]});
            right_w = expand12({byte_reg[1], byte_reg[2][3:0]});
        end
        else
        begin
            left_w  = {byte_reg[0], byte_reg[1]};
            right_w = {byte_reg[2], byte_reg[3]};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        CMD_ANALYZE: state_next = BK_HDR_RD;
                        CMD_READ:
                            state_next = (read_status == ST_OK) ? BK_CALC1 : BK_RESULT;
                        default:     state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CALC1:     state_next = BK_CALC2;
            BK_CALC2:     state_next = BK_CALC3;
            BK_CALC3:     state_next = BK_CALC4;
            BK_CALC4:     state_next = BK_FETCH;
            BK_FETCH:
            begin
                if (fetch_done)
                    state_next = (mode_reg == FM_PACK) ? BK_LATCH : BK_RESULT;
            end
            BK_HDR_RD:    state_next = BK_HDR_WAIT;
            BK_HDR_WAIT:  state_next = BK_PROBE_RD;
            BK_PROBE_RD:  state_next = BK_PROBE_CHK;
            BK_PROBE_CHK:
            begin
                if (probe_hit)
                    state_next = BK_FETCH;
                else if (probe_last)
                    state_next = BK_RESULT;
                else
                    state_next = BK_PROBE_RD;
            end
            BK_LATCH:     state_next = BK_RESULT;
            BK_RESULT:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default:      state_next = BK_IDLE;
        endcase
    end

    // memory port and queue pop
    always_comb
    begin
        q_pop         = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = q_cmd.addr;
        mem_req.wdata = q_cmd.value;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop      = q_valid;
                mem_req.we = q_valid && (q_cmd.kind == CMD_WRITE);
            end
            BK_HDR_RD:   mem_req.addr = HDR_ADDR;
            BK_PROBE_RD: mem_req.addr = probe_reg;
            BK_FETCH:    mem_req.addr = fetch_addr;
            default:     mem_req.addr = q_cmd.addr;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // latched frame info and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_valid_reg   <= 1'b0;
            rate_reg         <= RATE_UNKNOWN;
            count_reg        <= '0;
            fifty_reg        <= 1'b0;
            pal_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == BK_HDR_WAIT)
                pal_reg <= mem_rdata[7];
            if (state_reg == BK_PROBE_CHK && !probe_hit && probe_last)
            begin
                info_valid_reg <= 1'b0;
                rate_reg       <= RATE_UNKNOWN;
                count_reg      <= '0;
                fifty_reg      <= 1'b0;
            end
            if (state_reg == BK_LATCH)
            begin
                info_valid_reg <= 1'b1;
                rate_reg       <= new_rate;
                count_reg      <= (new_cnt > lim_cnt) ? lim_cnt : new_cnt;
                fifty_reg      <= new_fifty;
            end
            if (state_reg == BK_RESULT && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                idx_reg     <= q_cmd.index;
                is_read_reg <= (q_cmd.kind == CMD_READ);
                status_reg  <= (q_cmd.kind == CMD_READ) ? read_status : ST_OK;
                mode_reg    <= (rate_reg == RATE_32K) ? FM_PCM12 : FM_PCM16;
                fcnt_reg    <= '0;
            end
            BK_CALC1:
            begin
                q3_reg <= prod3[22:13];
                qg_reg <= prodg[21:16];
            end
            BK_CALC2:
            begin
                blk_reg    <= 4'(r3) * 4'd3 + 4'(subsel);
                byt_reg    <= 7'd8 + 7'(qg_reg) * ((mode_reg == FM_PCM12) ? 7'd3 : 7'd2);
                seqsum_reg <= q3_reg + 10'({r3, 1'b0});
            end
            BK_CALC3:
                seqq_reg <= prods[22:16];
            BK_CALC4:
            begin
                a_reg <= addr_a;
                b_reg <= addr_a + (pal_reg ? PAL_HALF : NTSC_HALF);
            end
            BK_FETCH:
            begin
                if (!fetch_done)
                    fcnt_reg <= fcnt_reg + 3'd1;
                if (fcnt_reg != 3'd0)
                    byte_reg[2'(fcnt_reg - 3'd1)] <= mem_rdata;
            end
            BK_HDR_WAIT:
            begin
                probe_reg   <= PROBE_FIRST;
                seq_cnt_reg <= '0;
                blk_cnt_reg <= '0;
            end
            BK_PROBE_CHK:
            begin
                if (probe_hit)
                begin
                    a_reg    <= probe_reg;
                    mode_reg <= FM_PACK;
                    fcnt_reg <= '0;
                end
                else if (probe_last)
                    status_reg <= ST_NO_INFO;
                else if (blk_cnt_reg == 4'd8)
                begin
                    blk_cnt_reg <= '0;
                    seq_cnt_reg <= seq_cnt_reg + 4'd1;
                    probe_reg   <= probe_reg + SEQ_WRAP;
                end
                else
                begin
                    blk_cnt_reg <= blk_cnt_reg + 4'd1;
                    probe_reg   <= probe_reg + BLOCK_STEP;
                end
            end
            BK_RESULT:
            begin
                if (out_free)
                begin
                    result_reg.status       <= status_reg;
                    result_reg.left_sample  <= left_w;
                    result_reg.right_sample <= right_w;
                    result_reg.sample_count <= count_reg;
                    result_reg.rate_code    <= rate_reg;
                    result_reg.is_pal       <= pal_reg;
                    result_reg.fifty_field  <= fifty_reg;
                end
            end
            default:
            begin
                fcnt_reg <= fcnt_reg;
            end
        endcase
    end

endmodule

FILE: rtl/dv_audio_deshuffle_extract_top.sv
// dv_audio_deshuffle_extract_top: a byte write is done at back-end dispatch; a pair read
// runs dispatch, four address stages, a 4 or 3 byte burst (4 at 48k or 44.1k, 3 at 32k)
// plus last-byte capture, then result load; a failing read skips to result load at dispatch.
// an analyze reads the header, then reads and checks each probed block on the single ram port.
// queue of two commands decouples input acceptance; rst_n clears control and frame info only.
// depends on dvad_pkg, dvad_front, dvad_queue, dvad_back, dvad_ram
module dv_audio_deshuffle_extract_top
    import dvad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    push_t      push;
    logic       queue_full;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;

    // front end: accept and classify
    dvad_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push)
    );

    // command queue
    dvad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (queue_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_cmd   (q_cmd)
    );

    // back end: execute against the frame ram
    dvad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // frame store
    dvad_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/dvad_checker.sv
// dvad_checker: port-level assertions for the dv audio deshuffle block, bound to the top
// depends on dvad_pkg and dv_audio_deshuffle_extract_top
module dvad_checker
    import dvad_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // samples are zero unless status is ok
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.left_sample == '0 && result.right_sample == '0)
        else $error("samples not zero on failing status");

    // no info means unknown rate and empty count
    a_noinfo: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_NO_INFO |->
            result.rate_code == RATE_UNKNOWN && result.sample_count == '0)
        else $error("stale info with no source pack");

    // count never exceeds the map length
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.sample_count <= COUNT_W'(PAL_PAIRS) &&
            (result.is_pal || result.sample_count <= COUNT_W'(NTSC_PAIRS)))
        else $error("sample count beyond map length");

endmodule

bind dv_audio_deshuffle_extract_top dvad_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
